### hdl/sensor_calibration_converter_defines.svh
// assertion macros shared by the sensor calibration converter rtl
// included by the files that carry concurrent checks; no other dependencies
`ifndef SENSOR_CALIBRATION_CONVERTER_DEFINES_SVH
`define SENSOR_CALIBRATION_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

`define SCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scc check failed");

`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scc check failed");

`else

`define SCC_ASSERT(label, clk, rst_n, prop)

`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/scc_pkg.sv
// shared constants and types of the sensor calibration converter
// used by the divider cells, the divider chain and the top level
package scc_pkg;

    // stream payload widths
    localparam int RAW_W     = 12;
    localparam int IN_DATA_W = 40;
    localparam int VAL_W     = 16;
    localparam int WHOLE_W   = 8;
    localparam int OUT_DATA_W = 56;

    // configuration port
    localparam int CFG_DATA_W = 12;
    typedef logic [7:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IDX_OFS_A = 8'd0;
    localparam t_cfg_idx CFG_IDX_OFS_B = 8'd1;

    // divider chain geometry
    localparam int DIV_LANES = 2;
    localparam int NUM_W     = 32;
    localparam int DEN1_W    = 16;
    localparam int DEN2_W    = 17;
    localparam int DEN_A_W   = 13;

    // numerators folded to k_raw * raw - k_ofs * offset + bias (mod 2^32)
    localparam logic [31:0] K_T_RAW  = 32'd11784;
    localparam logic [31:0] K_T_OFS  = 32'd10891;   // 11784 - 893
    localparam logic [31:0] K_T_BIAS = 32'd3657728; // subtracted
    localparam logic [31:0] K_H_RAW  = 32'd19554;
    localparam logic [31:0] K_H_OFS  = 32'd17172;   // 19554 - 2382
    localparam logic [31:0] K_H_BIAS = 32'd9756672; // subtracted
    localparam logic [31:0] K_P_RAW  = 32'd13889;
    localparam logic [31:0] K_P_OFS  = 32'd14945;   // 13889 + 1056
    localparam logic [31:0] K_P_BIAS = 32'd4325376; // added

    localparam logic [DEN_A_W-1:0] OFS_SPAN  = 13'd4096;
    localparam logic [DEN1_W-1:0]  DEC_SCALE = 16'd10;

    // divide by ten for a 16-bit value: (x * 52429) >> 19
    localparam logic [31:0] RECIP_TEN   = 32'd52429;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [31:0]       HUM_SCALE = 32'd10000;
    localparam logic [DEN2_W-1:0] COMP_BASE = 17'd105460;
    localparam logic [DEN2_W-1:0] COMP_STEP = 17'd216;

endpackage

### hdl/scc_div_cell.sv
// one restoring division step per lane, registered, for the scc divider chain
// parameter defaults come from scc_pkg
module scc_div_cell #(
    parameter int LANES = scc_pkg::DIV_LANES,
    parameter int N_W   = scc_pkg::NUM_W,
    parameter int D_W   = scc_pkg::DEN1_W,
    parameter int P_W   = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [LANES-1:0][D_W-1:0]       i_rem,
    input  logic [LANES-1:0][N_W-1:0]       i_acc,
    input  logic [LANES-1:0][D_W-1:0]       i_div,
    input  logic [P_W-1:0]                  i_pay,
    output logic                            o_valid,
    output logic [LANES-1:0][D_W-1:0]       o_rem,
    output logic [LANES-1:0][N_W-1:0]       o_acc,
    output logic [LANES-1:0][D_W-1:0]       o_div,
    output logic [P_W-1:0]                  o_pay
);

    logic [LANES-1:0][D_W:0]   trial;
    logic [LANES-1:0]          ge;
    logic [LANES-1:0][D_W-1:0] n_rem;
    logic [LANES-1:0][N_W-1:0] n_acc;

    logic                      r_valid;
    logic [LANES-1:0][D_W-1:0] r_rem;
    logic [LANES-1:0][N_W-1:0] r_acc;
    logic [LANES-1:0][D_W-1:0] r_div;
    logic [P_W-1:0]            r_pay;

    // acc holds the unused dividend bits on top and the quotient bits below
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {i_rem[l], i_acc[l][N_W-1]};
            ge[l]    = (trial[l] >= {1'b0, i_div[l]});
            n_rem[l] = ge[l] ? D_W'(trial[l] - {1'b0, i_div[l]}) : trial[l][D_W-1:0];
            n_acc[l] = {i_acc[l][N_W-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_div <= i_div;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
    assign o_div   = r_div;
    assign o_pay   = r_pay;

endmodule

### hdl/scc_div_chain.sv
// pipelined multi-lane divider: a row of N_W scc_div_cell stages
// depends on scc_pkg and sensor_calibration_converter_defines.svh
`include "sensor_calibration_converter_defines.svh"

module scc_div_chain #(
    parameter int LANES = scc_pkg::DIV_LANES,
    parameter int N_W   = scc_pkg::NUM_W,
    parameter int D_W   = scc_pkg::DEN1_W,
    parameter int P_W   = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [LANES-1:0][N_W-1:0]       i_num,
    input  logic [LANES-1:0][D_W-1:0]       i_div,
    input  logic [P_W-1:0]                  i_pay,
    output logic                            o_valid,
    output logic [LANES-1:0][N_W-1:0]       o_quot,
    output logic [P_W-1:0]                  o_pay
);

    logic [N_W:0]                       s_valid;
    logic [N_W:0][LANES-1:0][D_W-1:0]   s_rem;
    logic [N_W:0][LANES-1:0][N_W-1:0]   s_acc;
    logic [N_W:0][LANES-1:0][D_W-1:0]   s_div;
    logic [N_W:0][P_W-1:0]              s_pay;

    assign s_valid[0] = i_valid;
    assign s_rem[0]   = '0;
    assign s_acc[0]   = i_num;
    assign s_div[0]   = i_div;
    assign s_pay[0]   = i_pay;

    for (genvar i = 0; i < N_W; i++) begin : g_cell
        scc_div_cell #(
            .LANES (LANES),
            .N_W   (N_W),
            .D_W   (D_W),
            .P_W   (P_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (s_valid[i]),
            .i_rem   (s_rem[i]),
            .i_acc   (s_acc[i]),
            .i_div   (s_div[i]),
            .i_pay   (s_pay[i]),
            .o_valid (s_valid[i+1]),
            .o_rem   (s_rem[i+1]),
            .o_acc   (s_acc[i+1]),
            .o_div   (s_div[i+1]),
            .o_pay   (s_pay[i+1])
        );
    end

    assign o_valid = s_valid[N_W];
    assign o_quot  = s_acc[N_W];
    assign o_pay   = s_pay[N_W];

    // a finished division always leaves a remainder below its divisor
    for (genvar l = 0; l < LANES; l++) begin : g_chk
        `SCC_ASSERT(a_rem_below_div, i_clk, i_rst_n, s_valid[N_W] |-> (s_rem[N_W][l] < s_div[N_W][l]))
    end

endmodule

### hdl/sensor_calibration_converter.sv
// sensor_calibration_converter: stream in raw converter samples, stream out
// calibrated temperature, humidity and pressure
//
// input stream (s_axis): one transaction carries one set of raw 12-bit
// temperature, humidity and pressure samples. output stream (m_axis): one
// transaction per input set with the calibrated values. the config channel
// writes the two ground offsets; index 0 is offset a, index 1 offset b,
// other indexes are dropped. o_cfg_ready is always high.
// path from input acceptance to output valid: input stage, a 32-cell
// divider row for temperature and first humidity quotient, a scaling
// stage, a second 32-cell row for compensated humidity and pressure,
// output register. throughput: one set per cycle while o_s_axis_tready is
// high, as the one-bit-per-cell divider rows take a new operand each cycle.
// reset clears the offsets to zero and empties the pipeline and output.
// a stalled receiver keeps the pipeline running until one extra result
// lands in the skid register; o_s_axis_tready then drops until it drains.
`include "sensor_calibration_converter_defines.svh"

module sensor_calibration_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  scc_pkg::t_cfg_idx                i_cfg_addr,
    input  logic [scc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input samples
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [11:0] temperature_raw, [23:12] humidity_raw, [35:24] pressure_raw, [39:36] zero
    input  logic [scc_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // calibrated results
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [15:0] temperature_value, [23:16] temperature_whole,
    // [39:24] humidity_value, [55:40] pressure_value
    output logic [scc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    import scc_pkg::*;

    localparam int PAY1_W = NUM_W + DEN1_W;
    localparam int PAY2_W = WHOLE_W + VAL_W;

    logic                pipe_en;
    logic                out_free;

    // config
    logic [RAW_W-1:0]    r_ofs_a;
    logic [RAW_W-1:0]    r_ofs_b;

    // input stage
    logic [31:0]         raw_t, raw_h, raw_p, ofs_a32, ofs_b32;
    logic [DEN_A_W-1:0]  den_a, den_b;
    logic [NUM_W-1:0]    n_num_t, n_num_h, n_num_p;
    logic [DEN1_W-1:0]   n_div_t, n_div_h, n_div_p;
    logic                r_in_valid;
    logic [NUM_W-1:0]    r_num_t, r_num_h, r_num_p;
    logic [DEN1_W-1:0]   r_div_t, r_div_h, r_div_p;

    // first divider row
    logic [DIV_LANES-1:0][NUM_W-1:0]  c1_num;
    logic [DIV_LANES-1:0][DEN1_W-1:0] c1_div;
    logic                             c1_valid;
    logic [DIV_LANES-1:0][NUM_W-1:0]  c1_quot;
    logic [PAY1_W-1:0]                c1_pay;

    // scaling stage
    logic [31:0]         whole_prod;
    logic [NUM_W-1:0]    n_hprod;
    logic                r_x_valid;
    logic [VAL_W-1:0]    r_temp;
    logic [WHOLE_W-1:0]  r_whole;
    logic [NUM_W-1:0]    r_hprod;
    logic [NUM_W-1:0]    r_num_p2;
    logic [DEN1_W-1:0]   r_div_p2;
    logic [DEN2_W-1:0]   comp;

    // second divider row
    logic [DIV_LANES-1:0][NUM_W-1:0]  c2_num;
    logic [DIV_LANES-1:0][DEN2_W-1:0] c2_div;
    logic                             c2_valid;
    logic [DIV_LANES-1:0][NUM_W-1:0]  c2_quot;
    logic [PAY2_W-1:0]                c2_pay;
    logic [OUT_DATA_W-1:0]            c2_data;

    // output register and skid
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic                   r_skid_valid;
    logic [OUT_DATA_W-1:0]  r_skid_data;

    assign pipe_en         = !r_skid_valid;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = pipe_en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs_a <= '0;
            r_ofs_b <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_IDX_OFS_A: begin
                    r_ofs_a <= i_cfg_data;
                end
                CFG_IDX_OFS_B: begin
                    r_ofs_b <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // affine maps folded into one mod 2^32 expression per channel
    always_comb begin
        raw_t   = 32'(i_s_axis_tdata[RAW_W-1:0]);
        raw_h   = 32'(i_s_axis_tdata[2*RAW_W-1:RAW_W]);
        raw_p   = 32'(i_s_axis_tdata[3*RAW_W-1:2*RAW_W]);
        ofs_a32 = 32'(r_ofs_a);
        ofs_b32 = 32'(r_ofs_b);
        n_num_t = K_T_RAW * raw_t - K_T_OFS * ofs_a32 - K_T_BIAS;
        n_num_h = K_H_RAW * raw_h - K_H_OFS * ofs_a32 - K_H_BIAS;
        n_num_p = K_P_RAW * raw_p - K_P_OFS * ofs_b32 + K_P_BIAS;
        den_a   = OFS_SPAN - DEN_A_W'(r_ofs_a);
        den_b   = OFS_SPAN - DEN_A_W'(r_ofs_b);
        // the divide by ten folds into the divisor: x/10/d == x/(10*d)
        n_div_t = DEN1_W'(DEN1_W'(den_a) * DEC_SCALE);
        n_div_h = DEN1_W'(den_a);
        n_div_p = DEN1_W'(DEN1_W'(den_b) * DEC_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (pipe_en) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_num_t <= n_num_t;
            r_num_h <= n_num_h;
            r_num_p <= n_num_p;
            r_div_t <= n_div_t;
            r_div_h <= n_div_h;
            r_div_p <= n_div_p;
        end
    end

    always_comb begin
        c1_num[0] = r_num_t;
        c1_num[1] = r_num_h;
        c1_div[0] = r_div_t;
        c1_div[1] = r_div_h;
    end

    scc_div_chain #(
        .LANES (DIV_LANES),
        .N_W   (NUM_W),
        .D_W   (DEN1_W),
        .P_W   (PAY1_W)
    ) u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_in_valid),
        .i_num   (c1_num),
        .i_div   (c1_div),
        .i_pay   ({r_num_p, r_div_p}),
        .o_valid (c1_valid),
        .o_quot  (c1_quot),
        .o_pay   (c1_pay)
    );

    always_comb begin
        whole_prod = 32'(c1_quot[0][VAL_W-1:0]) * RECIP_TEN;
        n_hprod    = c1_quot[1] * HUM_SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (pipe_en) begin
            r_x_valid <= c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_temp   <= c1_quot[0][VAL_W-1:0];
            r_whole  <= whole_prod[RECIP_SHIFT +: WHOLE_W];
            r_hprod  <= n_hprod;
            r_num_p2 <= c1_pay[PAY1_W-1:DEN1_W];
            r_div_p2 <= c1_pay[DEN1_W-1:0];
        end
    end

    // temperature compensation divisor, never below 50380
    always_comb begin
        comp      = COMP_BASE - DEN2_W'(DEN2_W'(r_whole) * COMP_STEP);
        c2_num[0] = r_hprod;
        c2_num[1] = r_num_p2;
        c2_div[0] = comp;
        c2_div[1] = DEN2_W'(r_div_p2);
    end

    scc_div_chain #(
        .LANES (DIV_LANES),
        .N_W   (NUM_W),
        .D_W   (DEN2_W),
        .P_W   (PAY2_W)
    ) u_chain_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_x_valid),
        .i_num   (c2_num),
        .i_div   (c2_div),
        .i_pay   ({r_whole, r_temp}),
        .o_valid (c2_valid),
        .o_quot  (c2_quot),
        .o_pay   (c2_pay)
    );

    assign c2_data = {c2_quot[1][VAL_W-1:0], c2_quot[0][VAL_W-1:0], c2_pay};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= pipe_en && c2_valid;
            end
        end else if (pipe_en && c2_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : c2_data;
        end else if (pipe_en) begin
            r_skid_data <= c2_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `SCC_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    `SCC_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_axis_tready))
    `SCC_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_m_axis_tready, !r_skid_valid)

endmodule
